[rtl/core/drqr_pkg.sv]
// shared types, constants and helpers for the dns a-record responder
// no dependencies; imported by the front, queue, back and top-level modules and the testbench

package drqr_pkg;

  // name parsing limits
  localparam int unsigned MaxLabels = 31;
  localparam int unsigned LabelCntW = $clog2(MaxLabels + 1);

  // command queue between front and back
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);

  // configuration register indexes
  localparam logic CfgUseFixedIp = 1'b0;
  localparam logic CfgAnswerIp   = 1'b1;

  // header rewrite bytes
  localparam logic [7:0] FlagsHi   = 8'h81;
  localparam logic [7:0] FlagsLo   = 8'h80;
  localparam logic [7:0] CountOne  = 8'h01;
  localparam logic [7:0] ZeroByte  = 8'h00;

  // answer record layout: question byte, 12 fixed bytes, 4 address bytes
  localparam int unsigned AnsFixedLen = 12;
  localparam logic [4:0]  AnsLastPos  = 5'd16;
  localparam logic [7:0]  AnsFixed [AnsFixedLen] = '{
    8'hc0, 8'h0c, 8'h00, 8'h01, 8'h00, 8'h01,
    8'h00, 8'h00, 8'h00, 8'h05, 8'h00, 8'h04
  };

  // command codes carried through the queue
  typedef enum logic [1:0] {
    OpByte   = 2'd0,
    OpAbort  = 2'd1,
    OpAnswer = 2'd2
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e     op;
    logic [7:0]  data;
    logic [31:0] ip;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // byte of the answer burst at a given position
  function automatic logic [7:0] answer_byte(input logic [4:0] pos,
                                             input logic [7:0] first,
                                             input logic [31:0] ip);
    logic [7:0] res;
    logic [4:0] idx;
    idx = pos - 5'd1;
    res = ZeroByte;
    if (pos == 5'd0) begin
      res = first;
    end else if (pos <= 5'd12) begin
      res = AnsFixed[idx[3:0]];
    end else begin
      unique case (pos)
        5'd13:   res = ip[31:24];
        5'd14:   res = ip[23:16];
        5'd15:   res = ip[15:8];
        5'd16:   res = ip[7:0];
        default: res = ZeroByte;
      endcase
    end
    return res;
  endfunction

endpackage

[rtl/core/drqr_front.sv]
// front end: parses each query byte up to the answer into a command
// depends on drqr_pkg

module drqr_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           in_byte_i,
  input  logic                 in_last_i,
  input  logic [31:0]          src_ip_i,
  input  logic                 use_fixed_ip_i,
  input  logic [31:0]          answer_ip_i,
  output logic                 push_o,
  output drqr_pkg::cmd_t       cmd_o
);
  import drqr_pkg::*;

  typedef enum logic [5:0] {
    PhHeader = 6'b000001,
    PhLen    = 6'b000010,
    PhLabel  = 6'b000100,
    PhTerm   = 6'b001000,
    PhTail   = 6'b010000,
    PhDrop   = 6'b100000
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [3:0]           header_pos_q, header_pos_d;
  logic [6:0]           label_left_q, label_left_d;
  logic [LabelCntW-1:0] label_count_q, label_count_d;
  logic [1:0]           tail_pos_q, tail_pos_d;

  logic [7:0]           hdr_byte;
  logic [LabelCntW-1:0] label_count_inc;

  assign label_count_inc = label_count_q + LabelCntW'(1);

  // header rewrite
  always_comb begin
    unique case (header_pos_q)
      4'd2:                      hdr_byte = FlagsHi;
      4'd3:                      hdr_byte = FlagsLo;
      4'd6:                      hdr_byte = ZeroByte;
      4'd7:                      hdr_byte = CountOne;
      4'd8, 4'd9, 4'd10, 4'd11:  hdr_byte = ZeroByte;
      default:                   hdr_byte = in_byte_i;
    endcase
  end

  // parser next state and command
  always_comb begin
    phase_d       = phase_q;
    header_pos_d  = header_pos_q;
    label_left_d  = label_left_q;
    label_count_d = label_count_q;
    tail_pos_d    = tail_pos_q;
    push_o        = 1'b0;
    cmd_o.op      = OpByte;
    cmd_o.data    = in_byte_i;
    cmd_o.ip      = use_fixed_ip_i ? answer_ip_i : src_ip_i;

    if (accept_i) begin
      push_o = 1'b1;
      unique case (phase_q)
        PhHeader: begin
          cmd_o.data   = hdr_byte;
          header_pos_d = header_pos_q + 4'd1;
          if (header_pos_q == 4'd11) begin
            header_pos_d = 4'd0;
            phase_d      = PhLen;
          end
        end
        PhLen: begin
          if (in_byte_i == ZeroByte) begin
            phase_d    = PhTail;
            tail_pos_d = 2'd0;
          end else begin
            label_count_d = label_count_inc;
            label_left_d  = in_byte_i[6:0];
            if (in_byte_i[6:0] != 7'd0) begin
              phase_d = PhLabel;
            end else if (32'(label_count_inc) >= MaxLabels) begin
              phase_d = PhTerm;
            end else begin
              phase_d = PhLen;
            end
          end
        end
        PhLabel: begin
          label_left_d = label_left_q - 7'd1;
          if (label_left_q == 7'd1) begin
            phase_d = (32'(label_count_q) >= MaxLabels) ? PhTerm : PhLen;
          end
        end
        PhTerm: begin
          phase_d    = PhTail;
          tail_pos_d = 2'd0;
        end
        PhTail: begin
          if (tail_pos_q != 2'd3) begin
            tail_pos_d = tail_pos_q + 2'd1;
          end else begin
            cmd_o.op = OpAnswer;
            phase_d  = in_last_i ? PhHeader : PhDrop;
            if (in_last_i) begin
              tail_pos_d = 2'd0;
            end
          end
        end
        PhDrop: begin
          push_o = 1'b0;
          if (in_last_i) begin
            phase_d = PhHeader;
          end
        end
        default: begin
          push_o  = 1'b0;
          phase_d = PhHeader;
        end
      endcase

      // early end of the query turns the byte into an abort
      if (in_last_i && !(phase_q == PhDrop) &&
          !(phase_q == PhTail && tail_pos_q == 2'd3)) begin
        cmd_o.op      = OpAbort;
        cmd_o.data    = ZeroByte;
        phase_d       = PhHeader;
        header_pos_d  = 4'd0;
        label_left_d  = 7'd0;
        label_count_d = '0;
        tail_pos_d    = 2'd0;
      end
      if (phase_d == PhHeader) begin
        header_pos_d  = (phase_q == PhHeader && !in_last_i) ? header_pos_d : 4'd0;
        label_left_d  = (phase_q == PhHeader) ? label_left_d : 7'd0;
        label_count_d = (phase_q == PhHeader) ? label_count_d : '0;
        tail_pos_d    = 2'd0;
      end
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhHeader;
      header_pos_q  <= 4'd0;
      label_left_q  <= 7'd0;
      label_count_q <= '0;
      tail_pos_q    <= 2'd0;
    end else begin
      phase_q       <= phase_d;
      header_pos_q  <= header_pos_d;
      label_left_q  <= label_left_d;
      label_count_q <= label_count_d;
      tail_pos_q    <= tail_pos_d;
    end
  end

endmodule

[rtl/core/drqr_queue.sv]
// command queue between the parser and the response generator
// depends on drqr_pkg

module drqr_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  drqr_pkg::cmd_t       push_cmd_i,
  input  logic                 pop_i,
  output drqr_pkg::cmd_t       head_o,
  output drqr_pkg::q_status_t  status_o
);
  import drqr_pkg::*;

  cmd_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPtrW:0]   count_q, count_d;

  assign status_o.full  = (count_q == (QPtrW + 1)'(QueueDepth));
  assign status_o.empty = (count_q == '0);
  assign head_o         = mem_q[rd_ptr_q];

  // pointer and fill count
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QPtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + QPtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + (QPtrW + 1)'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - (QPtrW + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

[rtl/core/drqr_back.sv]
// back end: expands queued commands into response items on the output register
// depends on drqr_pkg

module drqr_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  drqr_pkg::cmd_t       head_i,
  input  drqr_pkg::q_status_t  status_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           out_byte_o,
  output logic                 out_kind_o,
  output logic                 out_last_o
);
  import drqr_pkg::*;

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_kind_q, out_kind_d;
  logic       out_last_q, out_last_d;
  logic [4:0] ans_pos_q, ans_pos_d;
  logic       load;

  assign load = !out_valid_q || out_ready_i;

  // command expansion
  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_kind_d  = out_kind_q;
    out_last_d  = out_last_q;
    ans_pos_d   = ans_pos_q;
    pop_o       = 1'b0;
    if (load) begin
      out_valid_d = !status_i.empty;
      if (!status_i.empty) begin
        unique case (head_i.op)
          OpAbort: begin
            out_byte_d = ZeroByte;
            out_kind_d = 1'b1;
            out_last_d = 1'b1;
            pop_o      = 1'b1;
          end
          OpAnswer: begin
            out_byte_d = answer_byte(ans_pos_q, head_i.data, head_i.ip);
            out_kind_d = 1'b0;
            out_last_d = (ans_pos_q == AnsLastPos);
            if (ans_pos_q == AnsLastPos) begin
              pop_o     = 1'b1;
              ans_pos_d = 5'd0;
            end else begin
              ans_pos_d = ans_pos_q + 5'd1;
            end
          end
          default: begin
            out_byte_d = head_i.data;
            out_kind_d = 1'b0;
            out_last_d = 1'b0;
            pop_o      = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      ans_pos_q   <= 5'd0;
    end else begin
      out_valid_q <= out_valid_d;
      ans_pos_q   <= ans_pos_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_kind_q <= out_kind_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_kind_o  = out_kind_q;
  assign out_last_o  = out_last_q;

endmodule

[rtl/core/dns_query_a_record_responder.sv]
// dns a-record responder: one query byte in, one response item out per cycle unless stalled
// an accepted byte's command is written into the queue, then expanded into the output register
// throughput: one item per cycle each way unless stalled; the answer command stays queued
//   for its 17 items, so at most three commands queue behind it before the input stalls
// reset: asynchronous active low; clears parser state, queue, output valid and registers
// depends on drqr_pkg, drqr_front, drqr_queue, drqr_back

module dns_query_a_record_responder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  input  logic [31:0] src_ip_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        out_kind_o,
  output logic        out_last_o
);
  import drqr_pkg::*;

  logic        use_fixed_ip_q;
  logic [31:0] answer_ip_q;
  logic        accept;
  logic        push;
  logic        pop;
  cmd_t        push_cmd;
  cmd_t        head;
  q_status_t   q_status;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_fixed_ip_q <= 1'b0;
      answer_ip_q    <= 32'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgUseFixedIp: use_fixed_ip_q <= cfg_wdata_i[0];
        CfgAnswerIp:   answer_ip_q    <= cfg_wdata_i;
        default:       ;
      endcase
    end
  end

  assign in_ready_o = !q_status.full;
  assign accept     = in_valid_i && in_ready_o;

  drqr_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .in_byte_i      (in_byte_i),
    .in_last_i      (in_last_i),
    .src_ip_i       (src_ip_i),
    .use_fixed_ip_i (use_fixed_ip_q),
    .answer_ip_i    (answer_ip_q),
    .push_o         (push),
    .cmd_o          (push_cmd)
  );

  drqr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .status_o   (q_status)
  );

  drqr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .status_i    (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .out_kind_o  (out_kind_o),
    .out_last_o  (out_last_o)
  );

endmodule

[rtl/core/drqr_checker.sv]
// port-level checks for the dns a-record responder, bound to the top level
// depends on dns_query_a_record_responder

module drqr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       out_kind_o,
  input logic       out_last_o
);

  // a stalled output item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o) &&
      $stable(out_kind_o) && $stable(out_last_o))
    else $error("output item changed while stalled");

  // an abort item is a lone zero byte closing the response
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o |-> out_byte_o == 8'h00 && out_last_o)
    else $error("malformed abort item");

  // no item is offered during or straight after reset
  assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid during reset");

  // an item newly offered must follow a taken input item, an earlier offered item or a ready receiver
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2) || $past(out_valid_o, 1) ||
      $past(in_valid_i && in_ready_o, 1) || $past(out_valid_o, 2) || $past(out_ready_i, 1))
    else $error("output item without preceding input item");

endmodule

bind dns_query_a_record_responder drqr_checker u_drqr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_byte_o  (out_byte_o),
  .out_kind_o  (out_kind_o),
  .out_last_o  (out_last_o)
);

[tb/sv/tb_dns_query_a_record_responder.sv]
// self-checking testbench for the dns a-record responder: directed and random query streams
// checked item by item against a built-in predictor of the header rewrite and answer record
// depends on drqr_pkg and dns_query_a_record_responder
`timescale 1ns / 1ps

module tb_dns_query_a_record_responder;
  import drqr_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int HoldCycles  = 300;
  localparam int DrainSlack  = 8;
  localparam int RandomBytes = 40;

  localparam logic KindByte  = 1'b0;
  localparam logic KindAbort = 1'b1;

  typedef enum logic [5:0] {
    PsHeader = 6'b000001,
    PsLen    = 6'b000010,
    PsLabel  = 6'b000100,
    PsTerm   = 6'b001000,
    PsTail   = 6'b010000,
    PsDrop   = 6'b100000
  } parse_e;

  typedef struct packed {
    logic [7:0] data;
    logic       kind;
    logic       last;
  } resp_item_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic        cfg_idx_i   = CfgUseFixedIp;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  in_byte_i   = '0;
  logic        in_last_i   = 1'b0;
  logic [31:0] src_ip_i    = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        out_kind_o;
  logic        out_last_o;

  dns_query_a_record_responder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .src_ip_i    (src_ip_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .out_kind_o  (out_kind_o),
    .out_last_o  (out_last_o)
  );

  // predictor copy of the registers and parser state
  logic        exp_fixed_ip  = 1'b0;
  logic [31:0] exp_answer_ip = '0;
  parse_e      ps            = PsHeader;
  logic [3:0]  hdr_pos       = '0;
  logic [6:0]  label_left    = '0;
  int          label_cnt     = 0;
  logic [1:0]  tail_pos      = '0;

  resp_item_t  resp_items_q[$];
  logic [7:0]  dgram_q[$];
  int          mismatch_cnt  = 0;
  int          cycle_cnt     = 0;
  int          bytes_sent    = 0;
  int          burst_left    = 0;
  bit          sender_steady = 1'b0;
  bit          hold_req      = 1'b0;

  // clock
  always #1 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("tb_dns_query_a_record_responder failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic void restart_parse();
    ps         = PsHeader;
    hdr_pos    = '0;
    label_left = '0;
    label_cnt  = 0;
    tail_pos   = '0;
  endfunction

  function automatic void push_resp(input logic [7:0] data, input logic kind,
                                    input logic last);
    resp_item_t it;
    it.data = data;
    it.kind = kind;
    it.last = last;
    resp_items_q.push_back(it);
  endfunction

  function automatic void push_abort();
    push_resp(ZeroByte, KindAbort, 1'b1);
    restart_parse();
  endfunction

  function automatic void end_of_label();
    ps = (label_cnt >= MaxLabels) ? PsTerm : PsLen;
  endfunction

  // expected response items caused by one query byte
  function automatic void respond_to_byte(input logic [7:0] b, input logic last,
                                          input logic [31:0] src);
    logic [7:0]  o;
    logic [31:0] ip;
    o = b;
    case (ps)
      PsHeader: begin
        case (hdr_pos)
          4'd2:                    o = FlagsHi;
          4'd3:                    o = FlagsLo;
          4'd6:                    o = ZeroByte;
          4'd7:                    o = CountOne;
          4'd8, 4'd9, 4'd10, 4'd11: o = ZeroByte;
          default:                 o = b;
        endcase
        if (last) begin
          push_abort();
        end else begin
          push_resp(o, KindByte, 1'b0);
          hdr_pos = hdr_pos + 4'd1;
          if (hdr_pos >= 4'd12) begin
            hdr_pos = '0;
            ps      = PsLen;
          end
        end
      end
      PsLen: begin
        if (last) begin
          push_abort();
        end else begin
          push_resp(b, KindByte, 1'b0);
          if (b == 8'h00) begin
            ps       = PsTail;
            tail_pos = '0;
          end else begin
            label_cnt  = label_cnt + 1;
            label_left = b[6:0];
            if (label_left == '0) end_of_label();
            else ps = PsLabel;
          end
        end
      end
      PsLabel: begin
        if (last) begin
          push_abort();
        end else begin
          push_resp(b, KindByte, 1'b0);
          label_left = label_left - 7'd1;
          if (label_left == '0) end_of_label();
        end
      end
      PsTerm: begin
        if (last) begin
          push_abort();
        end else begin
          push_resp(b, KindByte, 1'b0);
          ps       = PsTail;
          tail_pos = '0;
        end
      end
      PsTail: begin
        if (tail_pos < 2'd3) begin
          if (last) begin
            push_abort();
          end else begin
            push_resp(b, KindByte, 1'b0);
            tail_pos = tail_pos + 2'd1;
          end
        end else begin
          // last qclass byte, then the whole answer record
          ip = exp_fixed_ip ? exp_answer_ip : src;
          push_resp(b, KindByte, 1'b0);
          for (int i = 0; i < AnsFixedLen; i++) push_resp(AnsFixed[i], KindByte, 1'b0);
          push_resp(ip[31:24], KindByte, 1'b0);
          push_resp(ip[23:16], KindByte, 1'b0);
          push_resp(ip[15:8], KindByte, 1'b0);
          push_resp(ip[7:0], KindByte, 1'b1);
          if (last) restart_parse();
          else ps = PsDrop;
        end
      end
      default: begin
        if (last) restart_parse();
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // response checker
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    resp_item_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
      if (resp_items_q.size() == 0) begin
        $display("%0t: unexpected item byte=%h kind=%b last=%b", $time,
                 out_byte_o, out_kind_o, out_last_o);
        mismatch_cnt = mismatch_cnt + 1;
      end else begin
        want = resp_items_q.pop_front();
        if (out_byte_o !== want.data) begin
          $display("%0t: out_byte expected %h actual %h", $time, want.data, out_byte_o);
          mismatch_cnt = mismatch_cnt + 1;
        end
        if (out_kind_o !== want.kind) begin
          $display("%0t: out_kind expected %b actual %b", $time, want.kind, out_kind_o);
          mismatch_cnt = mismatch_cnt + 1;
        end
        if (out_last_o !== want.last) begin
          $display("%0t: out_last expected %b actual %b", $time, want.last, out_last_o);
          mismatch_cnt = mismatch_cnt + 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: stall patterns that change every so often, plus long hold-offs
  // ---------------------------------------------------------------------------

  initial begin
    int rx_cycles;
    int mode;
    rx_cycles = 0;
    mode      = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      rx_cycles = rx_cycles + 1;
      if (rx_cycles % 97 == 0) mode = $urandom_range(0, 3);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        rx_cycles = rx_cycles + HoldCycles;
        hold_req  = 1'b0;
        out_ready_i <= 1'b1;
      end else begin
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= $urandom_range(0, 1);
          2:       out_ready_i <= (rx_cycles % 4 != 0);
          default: out_ready_i <= (rx_cycles % 5 == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender and datagram building
  // ---------------------------------------------------------------------------

  // offer one query byte, bursts and gaps unless steady
  task automatic send_byte(input logic [7:0] b, input logic last, input logic [31:0] src);
    if (!sender_steady) begin
      if (burst_left == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        burst_left = $urandom_range(1, 16);
      end
      burst_left = burst_left - 1;
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    in_last_i  <= last;
    src_ip_i   <= src;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    bytes_sent = bytes_sent + 1;
    respond_to_byte(b, last, src);
  endtask

  task automatic send_dgram(input logic [31:0] src);
    for (int i = 0; i < dgram_q.size(); i++)
      send_byte(dgram_q[i], i == dgram_q.size() - 1, src);
  endtask

  function automatic void add_bytes(input int n, input bit rnd, input logic [7:0] fill);
    for (int i = 0; i < n; i++) dgram_q.push_back(rnd ? 8'($urandom) : fill);
  endfunction

  // length byte, optionally with the top bit set, then the label content
  function automatic void add_label(input int len, input bit hi);
    dgram_q.push_back(hi ? (8'h80 | 8'(len)) : 8'(len));
    add_bytes(len, 1'b1, 8'h00);
  endfunction

  // terminator slot, qtype/qclass, then bytes past the question
  function automatic void close_question(input logic [7:0] term, input int trail);
    dgram_q.push_back(term);
    add_bytes(4, 1'b1, 8'h00);
    add_bytes(trail, 1'b1, 8'h00);
  endfunction

  function automatic void cut_dgram(input int keep);
    while (dgram_q.size() > keep) void'(dgram_q.pop_back());
  endfunction

  // stop offering and wait for every expected item
  task automatic drain_responses();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (resp_items_q.size() != 0) @(posedge clk_i);
    repeat (DrainSlack) @(posedge clk_i);
  endtask

  task automatic set_config(input logic fixed, input logic [31:0] ip);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgUseFixedIp;
    cfg_wdata_i <= {31'b0, fixed};
    @(posedge clk_i);
    cfg_idx_i   <= CfgAnswerIp;
    cfg_wdata_i <= ip;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    exp_fixed_ip  = fixed;
    exp_answer_ip = ip;
    @(posedge clk_i);
  endtask

  // one random datagram: mostly well formed, some cut short, some noise
  task automatic send_random_query();
    int          pick;
    int          len;
    int          trail;
    logic [31:0] src;
    pick  = $urandom_range(0, 99);
    src   = $urandom;
    trail = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
    dgram_q.delete();
    sender_steady = ($urandom_range(0, 3) == 0);
    if (pick < 85) begin
      add_bytes(12, 1'b1, 8'h00);
      if (pick < 80) begin
        repeat ($urandom_range(0, 3)) begin
          len = $urandom_range(0, 5);
          add_label(len, len == 0 || $urandom_range(0, 4) == 0);
        end
        close_question(8'h00, trail);
        // cut before the last qclass byte so the query ends early
        if (pick >= 68) cut_dgram($urandom_range(1, dgram_q.size() - trail - 1));
      end else begin
        repeat (MaxLabels) begin
          len = $urandom_range(0, 1);
          add_label(len, len == 0);
        end
        close_question(8'($urandom), trail);
      end
    end else begin
      add_bytes($urandom_range(1, 24), 1'b1, 8'h00);
    end
    send_dgram(src);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // all-ones and all-zero headers, empty and high-bit labels, sender address echoed
  task automatic test_header_rewrite();
    dgram_q.delete();
    add_bytes(12, 1'b0, 8'hff);
    add_label(0, 1'b1);
    dgram_q.push_back(8'h81);
    dgram_q.push_back(8'hff);
    close_question(8'h00, 0);
    dgram_q[dgram_q.size() - 4] = 8'hff;
    send_dgram(32'hffff_ffff);
    dgram_q.delete();
    add_bytes(12, 1'b0, 8'h00);
    close_question(8'h00, 0);
    send_dgram(32'h0000_0000);
    drain_responses();
  endtask

  // query ends in the header, inside a label and inside qtype/qclass
  task automatic test_early_end();
    dgram_q.delete();
    dgram_q.push_back(8'h00);
    send_dgram($urandom);
    dgram_q.delete();
    add_bytes(12, 1'b1, 8'h00);
    add_label(2, 1'b0);
    cut_dgram(14);
    send_dgram($urandom);
    dgram_q.delete();
    add_bytes(12, 1'b1, 8'h00);
    close_question(8'h00, 0);
    cut_dgram(16);
    send_dgram($urandom);
    drain_responses();
  endtask

  // fixed answer address, bytes after the answer are dropped
  task automatic test_trailing_bytes();
    set_config(1'b1, 32'hffff_ffff);
    dgram_q.delete();
    add_bytes(12, 1'b1, 8'h00);
    add_label(3, 1'b0);
    close_question(8'h00, 3);
    send_dgram($urandom);
    drain_responses();
  endtask

  // after the label limit the terminator slot is copied whatever it holds
  task automatic test_label_limit();
    set_config(1'b0, 32'h0000_0000);
    dgram_q.delete();
    add_bytes(12, 1'b1, 8'h00);
    add_label(1, 1'b0);
    repeat (MaxLabels - 2) add_label(0, 1'b1);
    add_label(1, 1'b1);
    close_question(8'h3f, 0);
    send_dgram($urandom);
    drain_responses();
  endtask

  // receiver holds off while a steady sender fills the block
  task automatic test_backpressure();
    set_config(1'b1, $urandom);
    sender_steady = 1'b1;
    hold_req      = 1'b1;
    repeat (2) begin
      dgram_q.delete();
      add_bytes(12, 1'b1, 8'h00);
      add_label(4, 1'b0);
      close_question(8'h00, 1);
      send_dgram($urandom);
    end
    drain_responses();
    sender_steady = 1'b0;
  endtask

  // random datagrams across several register settings
  task automatic test_random_traffic();
    int start;
    for (int phase_n = 0; phase_n < 4; phase_n++) begin
      case (phase_n)
        0:       set_config(1'b1, 32'hffff_ffff);
        1:       set_config(1'b1, 32'h0000_0000);
        2:       set_config(1'b0, $urandom);
        default: set_config(1'b1, $urandom);
      endcase
      start = bytes_sent;
      while (bytes_sent - start < RandomBytes / 4) send_random_query();
      drain_responses();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_header_rewrite();
    test_early_end();
    test_trailing_bytes();
    test_label_limit();
    test_backpressure();
    test_random_traffic();
    drain_responses();
    if (resp_items_q.size() != 0) begin
      $display("%0t: %0d expected items never arrived", $time, resp_items_q.size());
      mismatch_cnt = mismatch_cnt + 1;
    end
    if (mismatch_cnt == 0) begin
      $display("tb_dns_query_a_record_responder passed");
    end else begin
      $display("tb_dns_query_a_record_responder failed");
    end
    $finish;
  end

endmodule
